// ===== rtl/slc_pkg.sv =====
`timescale 1ns / 1ps

package slc_pkg;

    // counter width, any value from 8 to 64
    localparam int COUNT_WIDTH = 32;
    localparam int REPORT_WIDTH = 32;
    localparam int EXT_WIDTH = (COUNT_WIDTH > REPORT_WIDTH) ? COUNT_WIDTH : REPORT_WIDTH + 1;

    typedef logic [COUNT_WIDTH-1:0] t_count;
    typedef logic [2:0] t_line_class;

    // line class codes
    localparam t_line_class LC_EMPTY      = 3'd0;
    localparam t_line_class LC_CODE       = 3'd1;
    localparam t_line_class LC_SLASH      = 3'd2;
    localparam t_line_class LC_SINGLE     = 3'd3;
    localparam t_line_class LC_BLOCK      = 3'd4;
    localparam t_line_class LC_BLOCK_STAR = 3'd5;
    localparam t_line_class LC_BLOCK_DONE = 3'd6;

    // input action codes
    localparam logic ACT_BYTE   = 1'b0;
    localparam logic ACT_REPORT = 1'b1;

    // character codes
    localparam logic [7:0] CH_NL     = 8'd10;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_STAR   = 8'd42;
    localparam logic [7:0] CH_SLASH  = 8'd47;
    localparam logic [7:0] CH_LBRACE = 8'd123;
    localparam logic [7:0] CH_RBRACE = 8'd125;

    // saturating increment
    function automatic t_count sat_inc(input t_count v);
        if (v == '1) begin
            return v;
        end
        return v + t_count'(1);
    endfunction

    // clip a count to the reported width
    function automatic logic [REPORT_WIDTH-1:0] clip_report(input t_count v);
        logic [EXT_WIDTH-1:0] e;
        e = EXT_WIDTH'(v);
        if (e > EXT_WIDTH'({REPORT_WIDTH{1'b1}})) begin
            return '1;
        end
        return e[REPORT_WIDTH-1:0];
    endfunction

endpackage

// ===== rtl/source_line_classifier_top.sv =====
`timescale 1ns / 1ps
// a report moves from the input register to the result register, waiting while a
//   full result is stalled; throughput: one word per cycle, bytes and reports alike,
//   unless a report waits; the line state and counter update after the input register sets it
// reset: synchronous, active low; clears the line state, all four counts and
//   both valid flags

module source_line_classifier_top
    import slc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_action,
    input  logic [7:0]  i_char_code,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_code_lines,
    output logic [31:0] o_cmt_lines,
    output logic [31:0] o_blank_lines,
    output logic [31:0] o_line_total
);

    logic        r_in_valid;
    logic        r_in_action;
    logic [7:0]  r_in_char;
    t_line_class r_class, n_class;
    t_count      r_code, n_code;
    t_count      r_comment, n_comment;
    t_count      r_empty, n_empty;
    t_count      r_total, n_total;
    logic        r_out_valid;
    logic [31:0] r_code_lines, r_cmt_lines, r_blank_lines, r_line_total;
    logic        advance;
    logic        in_accept;
    logic        report_go;

    // the held word moves on unless it is a report blocked by a full result
    assign advance   = (r_in_action == ACT_BYTE) || !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept = i_in_valid && !o_in_stall;
    assign report_go = r_in_valid && (r_in_action == ACT_REPORT) && advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_accept || (r_in_valid && !advance);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_action <= i_action;
            r_in_char   <= i_char_code;
        end
    end

    // line state and counter update
    always_comb begin
        n_class   = r_class;
        n_code    = r_code;
        n_comment = r_comment;
        n_empty   = r_empty;
        n_total   = r_total;
        if (r_in_valid && r_in_action == ACT_REPORT) begin
            n_class   = LC_EMPTY;
            n_code    = '0;
            n_comment = '0;
            n_empty   = '0;
            n_total   = '0;
        end else if (r_in_valid && r_in_char == CH_NL) begin
            // end of line
            n_total = sat_inc(r_total);
            unique case (r_class)
                LC_CODE: begin
                    n_code  = sat_inc(r_code);
                    n_class = LC_EMPTY;
                end
                LC_SINGLE, LC_BLOCK_DONE: begin
                    n_comment = sat_inc(r_comment);
                    n_class   = LC_EMPTY;
                end
                LC_BLOCK: begin
                    n_comment = sat_inc(r_comment);
                end
                LC_BLOCK_STAR: begin
                    n_comment = sat_inc(r_comment);
                    n_class   = LC_BLOCK;
                end
                LC_SLASH: begin
                    n_class = LC_SLASH;
                end
                default: begin
                    n_empty = sat_inc(r_empty);
                    n_class = LC_EMPTY;
                end
            endcase
        end else if (r_in_valid) begin
            // ordinary text byte
            unique case (r_class)
                LC_SLASH: begin
                    if (r_in_char == CH_SLASH) begin
                        n_class = LC_SINGLE;
                    end else if (r_in_char == CH_STAR) begin
                        n_class = LC_BLOCK;
                    end else begin
                        n_class = LC_CODE;
                    end
                end
                LC_BLOCK: begin
                    if (r_in_char == CH_STAR) begin
                        n_class = LC_BLOCK_STAR;
                    end
                end
                LC_BLOCK_STAR: begin
                    n_class = (r_in_char == CH_SLASH) ? LC_BLOCK_DONE : LC_BLOCK;
                end
                LC_CODE, LC_SINGLE, LC_BLOCK_DONE: begin
                    n_class = r_class;
                end
                default: begin
                    if (r_in_char == CH_SPACE || r_in_char == CH_LBRACE ||
                        r_in_char == CH_RBRACE) begin
                        n_class = LC_EMPTY;
                    end else if (r_in_char == CH_SLASH) begin
                        n_class = LC_SLASH;
                    end else begin
                        n_class = LC_CODE;
                    end
                end
            endcase
        end
    end

    // state registers, held while a report waits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_class   <= LC_EMPTY;
            r_code    <= '0;
            r_comment <= '0;
            r_empty   <= '0;
            r_total   <= '0;
        end else if (advance) begin
            r_class   <= n_class;
            r_code    <= n_code;
            r_comment <= n_comment;
            r_empty   <= n_empty;
            r_total   <= n_total;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (report_go) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (report_go) begin
            r_code_lines  <= clip_report(r_code);
            r_cmt_lines   <= clip_report(r_comment);
            r_blank_lines <= clip_report(r_empty);
            r_line_total  <= clip_report(r_total);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_code_lines  = r_code_lines;
    assign o_cmt_lines   = r_cmt_lines;
    assign o_blank_lines = r_blank_lines;
    assign o_line_total  = r_line_total;

endmodule

// ===== rtl/slc_checker.sv =====
`timescale 1ns / 1ps

module slc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        i_action,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_code_lines,
    input logic [31:0] o_cmt_lines,
    input logic [31:0] o_blank_lines,
    input logic [31:0] o_line_total
);

    // a stalled result word stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result word dropped while stalled");

    // a stalled result word keeps its counts
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_code_lines) &&
        $stable(o_cmt_lines) && $stable(o_blank_lines) && $stable(o_line_total))
        else $error("result word changed while stalled");

    // no class count can pass the total
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_code_lines <= o_line_total &&
        o_cmt_lines <= o_line_total && o_blank_lines <= o_line_total)
        else $error("class count above total");

    // a fresh result follows the acceptance of a report word
    a_report_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall && i_action, 2))
        else $error("result word without a report");

endmodule

bind source_line_classifier_top slc_checker u_slc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .i_action     (i_action),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_code_lines (o_code_lines),
    .o_cmt_lines  (o_cmt_lines),
    .o_blank_lines(o_blank_lines),
    .o_line_total (o_line_total)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import slc_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int TARGET_WORDS = 1500;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        logic [31:0] code;
        logic [31:0] comment;
        logic [31:0] empty;
        logic [31:0] total;
    } t_line_report;

    // line counter predictor and store of pending reports
    class line_count_board;
        t_line_class  state;
        t_count       code_n;
        t_count       comment_n;
        t_count       empty_n;
        t_count       total_n;
        t_line_report pending[$];
        int           errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            state = LC_EMPTY;
            code_n = '0;
            comment_n = '0;
            empty_n = '0;
            total_n = '0;
        endfunction

        // counts stick at all ones
        function t_count step_count(t_count v);
            if (v == {COUNT_WIDTH{1'b1}}) begin
                return v;
            end
            return v + 1'b1;
        endfunction

        function logic [31:0] narrow(t_count v);
            if (64'(v) > 64'hFFFF_FFFF) begin
                return 32'hFFFF_FFFF;
            end
            return 32'(v);
        endfunction

        // one text byte that is not a newline
        function void take_char(logic [7:0] ch);
            case (state)
                LC_SLASH: begin
                    if (ch == CH_SLASH) begin
                        state = LC_SINGLE;
                    end else if (ch == CH_STAR) begin
                        state = LC_BLOCK;
                    end else begin
                        state = LC_CODE;
                    end
                end
                LC_BLOCK: begin
                    if (ch == CH_STAR) begin
                        state = LC_BLOCK_STAR;
                    end
                end
                LC_BLOCK_STAR: begin
                    state = (ch == CH_SLASH) ? LC_BLOCK_DONE : LC_BLOCK;
                end
                LC_CODE, LC_SINGLE, LC_BLOCK_DONE: begin
                end
                default: begin
                    if (ch == CH_SPACE || ch == CH_LBRACE || ch == CH_RBRACE) begin
                        state = LC_EMPTY;
                    end else if (ch == CH_SLASH) begin
                        state = LC_SLASH;
                    end else begin
                        state = LC_CODE;
                    end
                end
            endcase
        endfunction

        // newline: class the finished line
        function void close_line();
            case (state)
                LC_CODE: begin
                    code_n = step_count(code_n);
                    state = LC_EMPTY;
                end
                LC_SINGLE, LC_BLOCK_DONE: begin
                    comment_n = step_count(comment_n);
                    state = LC_EMPTY;
                end
                LC_BLOCK: begin
                    comment_n = step_count(comment_n);
                end
                LC_BLOCK_STAR: begin
                    comment_n = step_count(comment_n);
                    state = LC_BLOCK;
                end
                LC_SLASH: begin
                end
                default: begin
                    empty_n = step_count(empty_n);
                    state = LC_EMPTY;
                end
            endcase
            total_n = step_count(total_n);
        endfunction

        function void note_word(logic act, logic [7:0] ch);
            t_line_report r;
            if (act == ACT_REPORT) begin
                r.code = narrow(code_n);
                r.comment = narrow(comment_n);
                r.empty = narrow(empty_n);
                r.total = narrow(total_n);
                pending.push_back(r);
                restart();
            end else if (ch == CH_NL) begin
                close_line();
            end else begin
                take_char(ch);
            end
        endfunction

        function void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
            if (got_v !== exp_v) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_report(logic [31:0] code, logic [31:0] comment,
                                   logic [31:0] empty, logic [31:0] total);
            t_line_report r;
            if (pending.size() == 0) begin
                $display("%0t: unexpected report, expected none, actual %0d %0d %0d %0d",
                         $time, code, comment, empty, total);
                errors++;
                return;
            end
            r = pending.pop_front();
            check_field("code_lines", r.code, code);
            check_field("cmt_lines", r.comment, comment);
            check_field("blank_lines", r.empty, empty);
            check_field("line_total", r.total, total);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_action;
    logic [7:0]  i_char_code;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_code_lines;
    logic [31:0] o_cmt_lines;
    logic [31:0] o_blank_lines;
    logic [31:0] o_line_total;

    line_count_board bench;
    int  words_sent;
    int  idle_cycles;
    bit  calm;

    source_line_classifier_top u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_action     (i_action),
        .i_char_code  (i_char_code),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_code_lines (o_code_lines),
        .o_cmt_lines  (o_cmt_lines),
        .o_blank_lines(o_blank_lines),
        .o_line_total (o_line_total)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm) begin
            return 0;
        end
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 50);
    endfunction

    // byte for comment bodies, rich in stars and slashes
    function automatic logic [7:0] body_char();
        int r;
        logic [7:0] c;
        r = $urandom_range(0, 9);
        if (r < 3) begin
            return CH_STAR;
        end
        if (r == 3) begin
            return CH_SLASH;
        end
        if (r == 4) begin
            return CH_SPACE;
        end
        c = 8'($urandom_range(0, 255));
        return (c == CH_NL) ? CH_SPACE : c;
    endfunction

    function automatic logic [7:0] blank_char();
        case ($urandom_range(0, 2))
            0: return CH_SPACE;
            1: return CH_LBRACE;
            default: return CH_RBRACE;
        endcase
    endfunction

    // one word on the input channel, held until taken
    task automatic send_word(input logic act, input logic [7:0] ch);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action <= act;
        i_char_code <= ch;
        do @(posedge i_clk); while (o_in_stall);
        bench.note_word(act, ch);
        words_sent++;
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) begin
            send_word(ACT_BYTE, s[k]);
        end
    endtask

    task automatic send_report();
        send_word(ACT_REPORT, 8'($urandom_range(0, 255)));
    endtask

    // hold the sender until every report is back
    task automatic drain_reports();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (bench.pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_body(input int n);
        repeat (n) send_word(ACT_BYTE, body_char());
    endtask

    // one line of random shape, usually well formed
    task automatic send_random_line();
        int kind;
        kind = $urandom_range(0, 9);
        case (kind)
            0: begin
                repeat ($urandom_range(0, 4)) send_word(ACT_BYTE, blank_char());
            end
            1: begin
                if ($urandom_range(0, 1)) send_word(ACT_BYTE, blank_char());
                repeat ($urandom_range(1, 8)) send_word(ACT_BYTE, 8'($urandom_range(33, 126)));
            end
            2: begin
                send_text("//");
                send_body($urandom_range(0, 6));
            end
            3: begin
                send_text("/*");
                send_body($urandom_range(0, 6));
            end
            4: begin
                send_body($urandom_range(0, 4));
                send_text("*/");
                send_body($urandom_range(0, 3));
            end
            5: begin
                repeat ($urandom_range(1, 10)) send_word(ACT_BYTE, 8'($urandom_range(0, 255)));
            end
            6: begin
                send_word(ACT_BYTE, CH_SLASH);
            end
            7: begin
                if ($urandom_range(0, 1)) send_text("/*");
                send_text("**/");
                send_body($urandom_range(0, 2));
            end
            8: begin
                send_text("/*");
                send_body($urandom_range(0, 4));
                send_text("*/");
                send_body($urandom_range(0, 3));
            end
            default: begin
                repeat ($urandom_range(0, 2)) send_word(ACT_BYTE, blank_char());
                send_word(ACT_BYTE, CH_SLASH);
                send_word(ACT_BYTE, body_char());
            end
        endcase
        if ($urandom_range(0, 9) != 0) begin
            send_word(ACT_BYTE, CH_NL);
        end
    endtask

    // receiver stall pattern
    initial begin
        int stall_left;
        int free_left;
        stall_left = 0;
        free_left = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (calm) begin
                i_out_stall <= 1'b0;
            end else if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else if (free_left > 0) begin
                i_out_stall <= 1'b0;
                free_left--;
            end else begin
                i_out_stall <= 1'b0;
                stall_left = pick_gap();
                free_left = $urandom_range(0, 8);
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            bench.check_report(o_code_lines, o_cmt_lines, o_blank_lines, o_line_total);
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid === 1'b1 && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus
    initial begin
        bit paused;
        bench = new();
        words_sent = 0;
        calm = 1'b0;
        paused = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_action = ACT_BYTE;
        i_char_code = 8'd0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: counts at zero, blank lines, comments, slash and star corners
        send_report();
        send_text("\n");
        send_text(" {}\n");
        send_text("//\n");
        send_text("/\n/\n");
        send_text("/***/\n");
        send_word(ACT_BYTE, 8'd255);
        send_text("\n*/q\n");
        send_word(ACT_BYTE, 8'd13);
        send_text("\n");
        send_word(ACT_BYTE, 8'd0);
        send_report();
        drain_reports();

        // random lines with reports mixed in
        while (words_sent < TARGET_WORDS) begin
            calm = ((words_sent / 250) % 3 == 2);
            if (!paused && words_sent > 700) begin
                paused = 1'b1;
                drain_reports();
            end
            send_random_line();
            if ($urandom_range(0, 5) == 0) begin
                send_report();
            end
        end
        send_report();

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (bench.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (bench.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
